// ----- hdl/prf_pkg.sv -----
`default_nettype none
package prf_pkg;

  // field widths
  localparam int PosW  = 40;              // Q16.24 position / radius
  localparam int InvW  = 32;              // Q16.16 inverse mass
  localparam int AccW  = 48;              // Q24.24 acceleration increment
  localparam int DistW = 2 * PosW + 1;    // squared distance
  localparam int RootW = PosW + 1;        // integer root of squared distance
  localparam int SclW  = RootW + InvW;    // |r - c| * inverse_mass
  localparam int DenW  = RootW + DistW;   // r * D
  localparam int ScaleSh = 32;            // extra fraction bits on the numerator
  localparam int NumW  = SclW + PosW + ScaleSh;
  localparam int QuoW  = AccW - 1;        // quotient bits below the cap

  // multiplier chunk size: bits of the B operand retired per stage
  localparam int MulChunk = 8;

  // stream and register port widths
  localparam int InDataW  = 4 * PosW;
  localparam int OutDataW = 4 * AccW;
  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 64;

  // register reset values
  localparam logic [PosW-1:0] CutoffRst = 40'd167772;
  localparam logic [PosW-1:0] MinRadRst = 40'd1678;
  localparam logic [InvW-1:0] InvMassRst = 32'd6553600;

  // signed saturating encode of a magnitude that is at most 2^47
  function automatic logic [AccW-1:0] encode(input logic [AccW-1:0] mag, input logic neg);
    logic [AccW-1:0] lim;
    logic [AccW-1:0] res;
    lim = {1'b0, {(AccW-1){1'b1}}};
    if (neg) begin
      res = AccW'(~mag + 1'b1);
    end else begin
      res = (mag > lim) ? lim : mag;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/prf_mul.sv -----
`default_nettype none
// Pipelined multiplier: B is retired CW bits per stage, the partial
// product shifted into a running sum. Several lanes share one tag.
module prf_mul #(
  parameter int AW    = 40,
  parameter int BW    = 40,
  parameter int CW    = 8,
  parameter int LANES = 1,
  parameter int TW    = 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic [LANES-1:0][AW-1:0]       a,
  input  wire logic [LANES-1:0][BW-1:0]       b,
  input  wire logic [TW-1:0]                  in_tag,
  output logic                                out_valid,
  output logic [LANES-1:0][AW+BW-1:0]         p,
  output logic [TW-1:0]                       out_tag
);
  localparam int NS = (BW + CW - 1) / CW;
  localparam int BP = NS * CW;
  localparam int PW = AW + BW;

  logic [NS-1:0]          v_r;
  logic [NS-1:0][TW-1:0]  tag_r;
  logic [PW-1:0]          acc_r [NS][LANES];
  logic [AW-1:0]          a_r   [NS][LANES];
  logic [BP-1:0]          b_r   [NS][LANES];

  wire [PW-1:0] acc_nxt [NS][LANES];
  wire [AW-1:0] a_nxt   [NS][LANES];
  wire [BP-1:0] b_nxt   [NS][LANES];

  // one partial product and one add per stage and lane
  for (genvar s = 0; s < NS; s++) begin : g_st
    for (genvar l = 0; l < LANES; l++) begin : g_ln
      wire [AW-1:0]    a_i;
      wire [BP-1:0]    b_i;
      wire [PW-1:0]    acc_i;
      wire [AW+CW-1:0] pp;
      if (s == 0) begin : g_first
        assign a_i   = a[l];
        assign b_i   = BP'(b[l]);
        assign acc_i = '0;
      end else begin : g_next
        assign a_i   = a_r[s-1][l];
        assign b_i   = b_r[s-1][l];
        assign acc_i = acc_r[s-1][l];
      end
      assign pp = a_i * b_i[s*CW +: CW];
      assign acc_nxt[s][l] = acc_i + (PW'(pp) << (s * CW));
      assign a_nxt[s][l]   = a_i;
      assign b_nxt[s][l]   = b_i;
    end
  end

  // valid and tag move with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r <= {tag_r[NS-2:0], in_tag};
      for (int s = 0; s < NS; s++) begin
        for (int l = 0; l < LANES; l++) begin
          acc_r[s][l] <= acc_nxt[s][l];
          a_r[s][l]   <= a_nxt[s][l];
          b_r[s][l]   <= b_nxt[s][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      p[l] = acc_r[NS-1][l];
    end
  end
  assign out_valid = v_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule
`default_nettype wire

// ----- hdl/prf_sqrt.sv -----
`default_nettype none
// Pipelined integer square root, one root bit per stage (restoring).
module prf_sqrt #(
  parameter int DW = 82,
  parameter int TW = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [DW-1:0]     d,
  input  wire logic [TW-1:0]     in_tag,
  output logic                   out_valid,
  output logic [DW/2-1:0]        root,
  output logic [TW-1:0]          out_tag
);
  localparam int QW = DW / 2;
  localparam int RW = QW + 2;

  logic [QW-1:0]         v_r;
  logic [QW-1:0][TW-1:0] tag_r;
  logic [RW-1:0]         rem_r  [QW];
  logic [QW-1:0]         root_r [QW];
  logic [DW-1:0]         d_r    [QW];

  wire [RW-1:0] rem_nxt  [QW];
  wire [QW-1:0] root_nxt [QW];
  wire [DW-1:0] d_nxt    [QW];

  // bring down two radicand bits, try root*4+1
  for (genvar s = 0; s < QW; s++) begin : g_st
    wire [RW-1:0]   rem_i;
    wire [QW-1:0]   root_i;
    wire [DW-1:0]   d_i;
    wire [RW+1:0]   t;
    wire [RW+1:0]   trial;
    wire            ge;
    if (s == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign d_i    = d;
    end else begin : g_next
      assign rem_i  = rem_r[s-1];
      assign root_i = root_r[s-1];
      assign d_i    = d_r[s-1];
    end
    assign t     = {rem_i, d_i[DW-1 -: 2]};
    assign trial = (RW+2)'({root_i, 2'b01});
    assign ge    = (t >= trial);
    assign rem_nxt[s]  = ge ? RW'(t - trial) : RW'(t);
    assign root_nxt[s] = {root_i[QW-2:0], ge};
    assign d_nxt[s]    = d_i << 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r <= {tag_r[QW-2:0], in_tag};
      for (int s = 0; s < QW; s++) begin
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        d_r[s]    <= d_nxt[s];
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign root      = root_r[QW-1];
  assign out_tag   = tag_r[QW-1];

endmodule
`default_nettype wire

// ----- hdl/prf_div.sv -----
`default_nettype none
// Pipelined restoring divider with a capped quotient. The first stage
// flags num >= den * 2^QB (result 2^QB); then one quotient bit per stage.
module prf_div #(
  parameter int NW    = 145,
  parameter int DW    = 122,
  parameter int QB    = 47,
  parameter int LANES = 2,
  parameter int TW    = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [LANES-1:0][NW-1:0]  num,
  input  wire logic [DW-1:0]             den,
  input  wire logic [TW-1:0]             in_tag,
  output logic                           out_valid,
  output logic [LANES-1:0][QB:0]         q,
  output logic [TW-1:0]                  out_tag
);
  localparam int WW = DW + QB;
  localparam int NS = QB + 1;

  logic [NS-1:0]            v_r;
  logic [NS-1:0][TW-1:0]    tag_r;
  logic [NS-1:0][DW-1:0]    den_r;
  logic [NS-1:0][LANES-1:0] cap_r;
  logic [WW-1:0]            rem_r [NS][LANES];
  logic [QB-1:0]            q_r   [NS][LANES];

  wire [WW-1:0]    rem_nxt [NS][LANES];
  wire [QB-1:0]    q_nxt   [NS][LANES];
  wire [LANES-1:0] cap_nxt;

  for (genvar l = 0; l < LANES; l++) begin : g_cap
    assign cap_nxt[l]    = (WW'(num[l]) >= (WW'(den) << QB));
    assign rem_nxt[0][l] = WW'(num[l]);
    assign q_nxt[0][l]   = '0;
  end

  // stage s settles quotient bit QB-s
  for (genvar s = 1; s < NS; s++) begin : g_st
    for (genvar l = 0; l < LANES; l++) begin : g_ln
      wire [WW-1:0] rem_i;
      wire [WW-1:0] sh;
      wire          ge;
      assign rem_i = rem_r[s-1][l];
      assign sh    = WW'(den_r[s-1]) << (QB - s);
      assign ge    = (rem_i >= sh);
      assign rem_nxt[s][l] = ge ? (rem_i - sh) : rem_i;
      assign q_nxt[s][l]   = q_r[s-1][l] | (QB'(ge) << (QB - s));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r <= {tag_r[NS-2:0], in_tag};
      den_r <= {den_r[NS-2:0], den};
      cap_r <= {cap_r[NS-2:0], cap_nxt};
      for (int s = 0; s < NS; s++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= rem_nxt[s][l];
          q_r[s][l]   <= q_nxt[s][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q[l] = cap_r[NS-1][l] ? {1'b1, {QB{1'b0}}} : {1'b0, q_r[NS-1][l]};
    end
  end
  assign out_valid = v_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule
`default_nettype wire

// ----- hdl/pair_repulsive_force.sv -----
`default_nettype none
// Short-range repulsive pair force.
// Input stream: one particle pair per item, in_tdata holds four unsigned
// Q16.24 positions. Output stream: one result per item, out_tuser[0] is
// the interaction flag and out_tdata the four signed Q24.24 increments;
// all increments are zero when the pair is beyond the cutoff.
// Registers on the APB port (64-bit data, byte address 8*index):
// cutoff_radius, minimum_radius, inverse_mass. Write them only while the
// pipeline is empty.
// Throughput: one item per cycle unless the sink stalls. Depth: 109
// register stages, set by the 41-stage square root, the 48-stage divider
// and the three chunked multipliers (8 multiplier bits per stage).
// When a result waits with out_tready low the whole pipeline holds; a
// one-item input skid register still takes an item, then in_tready drops
// until the sink drains. Reset empties the pipeline and the skid register
// and loads the register defaults; no items are lost or repeated under stalls.
module pair_repulsive_force (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // self_x, self_y, other_x, other_y (low to high)
  input  wire logic [prf_pkg::InDataW-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // self_dax, self_day, other_dax, other_day (low to high)
  output logic [prf_pkg::OutDataW-1:0]       out_tdata,
  // interacts
  output logic [0:0]                         out_tuser,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [prf_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  wire logic [prf_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [prf_pkg::CfgDataW-1:0]       cfg_prdata,
  output logic                               cfg_pready
);
  localparam int PW  = prf_pkg::PosW;
  localparam int IW  = prf_pkg::InvW;
  localparam int RW  = prf_pkg::RootW;
  localparam int DW  = prf_pkg::DistW;
  localparam int SW  = prf_pkg::SclW;
  localparam int DNW = prf_pkg::DenW;
  localparam int NW  = prf_pkg::NumW;
  localparam int QB  = prf_pkg::QuoW;
  localparam int AW  = prf_pkg::AccW;
  localparam int CH  = prf_pkg::MulChunk;
  localparam int XW  = prf_pkg::ScaleSh;
  localparam int CDW = prf_pkg::CfgDataW;

  localparam logic [1:0] RegCutoff  = 2'd0;
  localparam logic [1:0] RegMinRad  = 2'd1;
  localparam logic [1:0] RegInvMass = 2'd2;

  // tag widths between units
  localparam int T1W = 2 * PW + 4;
  localparam int T2W = T1W + 1 + DW;
  localparam int T3W = 2 * PW + 3;
  localparam int T4W = DNW + 3;

  // ---------------- configuration registers
  logic [PW-1:0] cutoff_r;
  logic [PW-1:0] minrad_r;
  logic [IW-1:0] invmass_r;
  logic [1:0]    reg_sel;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[prf_pkg::CfgAddrW-1:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r  <= prf_pkg::CutoffRst;
      minrad_r  <= prf_pkg::MinRadRst;
      invmass_r <= prf_pkg::InvMassRst;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegCutoff:  cutoff_r  <= cfg_pwdata[PW-1:0];
        RegMinRad:  minrad_r  <= cfg_pwdata[PW-1:0];
        RegInvMass: invmass_r <= cfg_pwdata[IW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegCutoff:  cfg_prdata = CDW'(cutoff_r);
      RegMinRad:  cfg_prdata = CDW'(minrad_r);
      RegInvMass: cfg_prdata = CDW'(invmass_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline enable and input skid
  logic                         en;
  logic                         skid_valid_r;
  logic [prf_pkg::InDataW-1:0]  skid_data_r;
  logic                         src_valid;
  logic [prf_pkg::InDataW-1:0]  src_data;
  logic                         in_acc;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign src_valid = skid_valid_r || in_tvalid;
  assign src_data  = skid_valid_r ? skid_data_r : in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else if (en) begin
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !en) begin
      skid_data_r <= in_tdata;
    end
  end

  // ---------------- stage A: deltas, magnitudes and signs
  logic [PW:0]   dx;
  logic [PW:0]   dy;
  logic          a_valid_r;
  logic [PW-1:0] a_adx_r;
  logic [PW-1:0] a_ady_r;
  logic [3:0]    a_sgn_r;   // {dy != 0, dy < 0, dx != 0, dx < 0}

  assign dx = {1'b0, src_data[3*PW-1:2*PW]} - {1'b0, src_data[PW-1:0]};
  assign dy = {1'b0, src_data[4*PW-1:3*PW]} - {1'b0, src_data[2*PW-1:PW]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_adx_r <= dx[PW] ? PW'(-dx) : dx[PW-1:0];
      a_ady_r <= dy[PW] ? PW'(-dy) : dy[PW-1:0];
      a_sgn_r <= {(dy != '0), dy[PW], (dx != '0), dx[PW]};
    end
  end

  // ---------------- squares: dx^2, dy^2, c^2, min^2
  logic [PW-1:0]            minrad_eff;
  logic [3:0][PW-1:0]       m1_a;
  logic [3:0][2*PW-1:0]     m1_p;
  logic                     m1_valid;
  logic [T1W-1:0]           m1_tag;

  assign minrad_eff = (minrad_r == '0) ? PW'(1) : minrad_r;
  assign m1_a = {cutoff_r, minrad_eff, a_ady_r, a_adx_r};

  prf_mul #(.AW(PW), .BW(PW), .CW(CH), .LANES(4), .TW(T1W)) u_mul_sq (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_valid_r),
    .a         (m1_a),
    .b         (m1_a),
    .in_tag    ({a_adx_r, a_ady_r, a_sgn_r}),
    .out_valid (m1_valid),
    .p         (m1_p),
    .out_tag   (m1_tag)
  );

  // ---------------- stage B: distance, cutoff test, clamp
  logic [DW-1:0]  dsq;
  logic [DW-1:0]  lim;
  logic           b_valid_r;
  logic           b_inter_r;
  logic [DW-1:0]  b_dc_r;
  logic [T1W-1:0] b_tag_r;

  assign dsq = DW'(m1_p[0]) + DW'(m1_p[1]);
  assign lim = DW'(m1_p[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_inter_r <= (dsq <= DW'(m1_p[3]));
      b_dc_r    <= (dsq < lim) ? lim : dsq;
      b_tag_r   <= m1_tag;
    end
  end

  // ---------------- square root
  logic           sq_valid;
  logic [RW-1:0]  sq_root;
  logic [T2W-1:0] sq_tag;
  logic [DW-1:0]  sq_dc;
  logic           sq_inter;
  logic [PW-1:0]  sq_adx;
  logic [PW-1:0]  sq_ady;
  logic [3:0]     sq_sgn;

  prf_sqrt #(.DW(2 * RW), .TW(T2W)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_valid_r),
    .d         ((2 * RW)'(b_dc_r)),
    .in_tag    ({b_tag_r, b_inter_r, b_dc_r}),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_tag   (sq_tag)
  );

  assign {sq_adx, sq_ady, sq_sgn, sq_inter, sq_dc} = sq_tag;

  // ---------------- stage C: |r - c| and result signs
  logic [RW-1:0] c_ext;
  logic          above;
  logic          c_valid_r;
  logic [RW-1:0] c_root_r;
  logic [RW-1:0] c_mag_r;
  logic [DW-1:0] c_dc_r;
  logic [PW-1:0] c_adx_r;
  logic [PW-1:0] c_ady_r;
  logic [1:0]    c_neg_r;   // {y negative, x negative} for the particle
  logic          c_inter_r;

  assign c_ext = RW'(cutoff_r);
  assign above = sq_root > c_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_root_r  <= sq_root;
      c_mag_r   <= above ? (sq_root - c_ext) : (c_ext - sq_root);
      c_dc_r    <= sq_dc;
      c_adx_r   <= sq_adx;
      c_ady_r   <= sq_ady;
      c_neg_r[0] <= above ? sq_sgn[0] : (sq_sgn[1] && !sq_sgn[0]);
      c_neg_r[1] <= above ? sq_sgn[2] : (sq_sgn[3] && !sq_sgn[2]);
      c_inter_r <= sq_inter;
    end
  end

  // ---------------- r * D and |r - c| * inverse_mass
  logic [1:0][DW-1:0]     m2_a;
  logic [1:0][RW-1:0]     m2_b;
  logic [1:0][DNW-1:0]    m2_p;
  logic                   m2_valid;
  logic [T3W-1:0]         m2_tag;

  assign m2_a = {DW'(invmass_r), c_dc_r};
  assign m2_b = {c_mag_r, c_root_r};

  prf_mul #(.AW(DW), .BW(RW), .CW(CH), .LANES(2), .TW(T3W)) u_mul_den (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_valid_r),
    .a         (m2_a),
    .b         (m2_b),
    .in_tag    ({c_adx_r, c_ady_r, c_neg_r, c_inter_r}),
    .out_valid (m2_valid),
    .p         (m2_p),
    .out_tag   (m2_tag)
  );

  // ---------------- scale * |dx|, scale * |dy|
  logic [PW-1:0]          m2_adx;
  logic [PW-1:0]          m2_ady;
  logic [2:0]             m2_misc;
  logic [1:0][SW-1:0]     m3_a;
  logic [1:0][PW-1:0]     m3_b;
  logic [1:0][SW+PW-1:0]  m3_p;
  logic                   m3_valid;
  logic [T4W-1:0]         m3_tag;

  assign {m2_adx, m2_ady, m2_misc} = m2_tag;
  assign m3_a = {m2_p[1][SW-1:0], m2_p[1][SW-1:0]};
  assign m3_b = {m2_ady, m2_adx};

  prf_mul #(.AW(SW), .BW(PW), .CW(CH), .LANES(2), .TW(T4W)) u_mul_num (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (m2_valid),
    .a         (m3_a),
    .b         (m3_b),
    .in_tag    ({m2_p[0], m2_misc}),
    .out_valid (m3_valid),
    .p         (m3_p),
    .out_tag   (m3_tag)
  );

  // ---------------- division
  logic [DNW-1:0]      m3_den;
  logic [2:0]          m3_misc;
  logic [1:0][NW-1:0]  dv_num;
  logic                dv_valid;
  logic [1:0][QB:0]    dv_q;
  logic [2:0]          dv_misc;   // {y negative, x negative, interacts}

  assign {m3_den, m3_misc} = m3_tag;
  assign dv_num = {{m3_p[1], {XW{1'b0}}}, {m3_p[0], {XW{1'b0}}}};

  prf_div #(.NW(NW), .DW(DNW), .QB(QB), .LANES(2), .TW(3)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (m3_valid),
    .num       (dv_num),
    .den       (m3_den),
    .in_tag    (m3_misc),
    .out_valid (dv_valid),
    .q         (dv_q),
    .out_tag   (dv_misc)
  );

  // ---------------- output register: sign, saturate, zero when no interaction
  logic          out_valid_r;
  logic [AW-1:0] sdx_nxt;
  logic [AW-1:0] sdy_nxt;
  logic [AW-1:0] odx_nxt;
  logic [AW-1:0] ody_nxt;
  logic [prf_pkg::OutDataW-1:0] out_data_r;
  logic          out_inter_r;

  always_comb begin
    if (dv_misc[0]) begin
      sdx_nxt = prf_pkg::encode(AW'(dv_q[0]), dv_misc[1]);
      sdy_nxt = prf_pkg::encode(AW'(dv_q[1]), dv_misc[2]);
      odx_nxt = prf_pkg::encode(AW'(dv_q[0]), !dv_misc[1]);
      ody_nxt = prf_pkg::encode(AW'(dv_q[1]), !dv_misc[2]);
    end else begin
      sdx_nxt = '0;
      sdy_nxt = '0;
      odx_nxt = '0;
      ody_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r  <= {ody_nxt, odx_nxt, sdy_nxt, sdx_nxt};
      out_inter_r <= dv_misc[0];
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_inter_r;

endmodule
`default_nettype wire

// ----- hdl/prf_chk.sv -----
`default_nettype none
// Port-level checks for the pair force block.
module prf_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [prf_pkg::OutDataW-1:0] out_tdata,
  input wire logic [0:0]                   out_tuser
);
  localparam int AW = prf_pkg::AccW;

  logic [AW-1:0] sum_x;
  logic [AW-1:0] sum_y;

  // neighbor increment is the negation, or off by one at saturation
  assign sum_x = out_tdata[AW-1:0] + out_tdata[3*AW-1:2*AW];
  assign sum_y = out_tdata[2*AW-1:AW] + out_tdata[4*AW-1:3*AW];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no interaction gives zero increments
  a_zero_far: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("nonzero increment without interaction");

  a_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (sum_x == '0 || sum_x == '1) && (sum_y == '0 || sum_y == '1))
    else $error("neighbor increment is not the negation");

  // reset empties the output and the input skid
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

endmodule

bind pair_repulsive_force prf_chk u_prf_chk (.*);
`default_nettype wire

// ----- tb/tb_pair_repulsive_force.sv -----
`default_nettype none

typedef struct packed {
  logic [39:0] sx;
  logic [39:0] sy;
  logic [39:0] ox;
  logic [39:0] oy;
} pair_pos_t;

typedef struct packed {
  logic        interacts;
  logic [47:0] self_dax;
  logic [47:0] self_day;
  logic [47:0] other_dax;
  logic [47:0] other_day;
} pair_force_t;

// Expected pair forces, computed with exact wide integer math
class force_scoreboard;
  pair_force_t expected_q[$];
  logic [39:0] cutoff;
  logic [39:0] min_rad;
  logic [31:0] inv_mass;
  int          errors;
  int          checked;
  int          hits;

  function new();
    cutoff   = prf_pkg::CutoffRst;
    min_rad  = prf_pkg::MinRadRst;
    inv_mass = prf_pkg::InvMassRst;
    errors   = 0;
    checked  = 0;
    hits     = 0;
  endfunction

  function automatic logic [47:0] saturate(logic [47:0] mag, logic neg);
    if (neg) return 48'(~mag + 48'd1);
    return (mag > 48'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : mag;
  endfunction

  function automatic logic [47:0] scaled_quot(logic [191:0] num, logic [191:0] den);
    logic [191:0] q;
    q = num / den;
    return (q >= (192'd1 << 47)) ? 48'h8000_0000_0000 : q[47:0];
  endfunction

  // queue the force that the block must produce for this pair
  function void note_pair(pair_pos_t p);
    pair_force_t  f;
    logic signed [41:0] dx, dy;
    logic [191:0] adx, ady, d, cc, lim, r, cand, c, mr, mag, den, scale;
    logic [47:0]  qx, qy;
    logic         above, nx, ny;
    dx = $signed({2'b00, p.ox}) - $signed({2'b00, p.sx});
    dy = $signed({2'b00, p.oy}) - $signed({2'b00, p.sy});
    adx = (dx < 0) ? 192'(-dx) : 192'(dx);
    ady = (dy < 0) ? 192'(-dy) : 192'(dy);
    c  = 192'(cutoff);
    mr = (min_rad == 0) ? 192'd1 : 192'(min_rad);
    d  = adx * adx + ady * ady;
    cc = c * c;
    f  = '0;
    if (d <= cc) begin
      f.interacts = 1'b1;
      lim = mr * mr;
      if (d < lim) d = lim;
      r = 0;
      for (int b = 40; b >= 0; b--) begin
        cand = r | (192'd1 << b);
        if (cand * cand <= d) r = cand;
      end
      above = r > c;
      mag   = above ? r - c : c - r;
      den   = r * d;
      scale = (mag * 192'(inv_mass)) << 32;
      qx = scaled_quot(scale * adx, den);
      qy = scaled_quot(scale * ady, den);
      nx = above ? (dx < 0) : (dx > 0);
      ny = above ? (dy < 0) : (dy > 0);
      f.self_dax  = saturate(qx, nx);
      f.self_day  = saturate(qy, ny);
      f.other_dax = saturate(qx, !nx);
      f.other_day = saturate(qy, !ny);
      hits++;
    end
    expected_q.insert(expected_q.size(), f);
  endfunction

  function void check_force(pair_force_t got);
    pair_force_t e;
    checked++;
    if (expected_q.size() == 0) begin
      $error("unexpected result item: %p", got);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (got.interacts !== e.interacts) begin
      $error("interacts: expected %0d, got %0d", e.interacts, got.interacts);
      errors++;
    end
    if (got.self_dax !== e.self_dax) begin
      $error("self_dax: expected %h, got %h", e.self_dax, got.self_dax);
      errors++;
    end
    if (got.self_day !== e.self_day) begin
      $error("self_day: expected %h, got %h", e.self_day, got.self_day);
      errors++;
    end
    if (got.other_dax !== e.other_dax) begin
      $error("other_dax: expected %h, got %h", e.other_dax, got.other_dax);
      errors++;
    end
    if (got.other_day !== e.other_day) begin
      $error("other_day: expected %h, got %h", e.other_day, got.other_day);
      errors++;
    end
  endfunction
endclass

module tb_pair_repulsive_force;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 5000;
  localparam int Latency    = 109;
  localparam int PerPhase   = 240;
  localparam logic [39:0] PosMax = 40'hFF_FFFF_FFFF;

  typedef enum logic [4:0] {
    REG_CUTOFF  = 5'd0,
    REG_MIN_RAD = 5'd8,
    REG_INV_MASS = 5'd16
  } reg_addr_e;

  logic clk;
  logic rst_n;
  logic in_tvalid, in_tready;
  logic [prf_pkg::InDataW-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [prf_pkg::OutDataW-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [prf_pkg::CfgAddrW-1:0] cfg_paddr;
  logic [prf_pkg::CfgDataW-1:0] cfg_pwdata, cfg_prdata;

  force_scoreboard sb = new();
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_len;
  int quiet_cycles;
  int sent;

  pair_repulsive_force uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sink: random backpressure, long hold-off on request, result checking, watchdog
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      sb.check_force({out_tuser[0], out_tdata[47:0], out_tdata[95:48],
                      out_tdata[143:96], out_tdata[191:144]});
    end
    if (hold_len > 0) begin
      hold_len = hold_len - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("timeout: no item moved for %0d cycles", StallLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(reg_addr_e addr, logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [39:0] c, logic [39:0] mr, logic [31:0] im);
    write_reg(REG_CUTOFF, 64'(c));
    write_reg(REG_MIN_RAD, 64'(mr));
    write_reg(REG_INV_MASS, 64'(im));
    sb.cutoff   = c;
    sb.min_rad  = mr;
    sb.inv_mass = im;
  endtask

  task automatic send_pair(pair_pos_t p);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.oy, p.ox, p.sy, p.sx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pair(p);
    sent++;
  endtask

  // sender pauses until every expected result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  function automatic logic [39:0] rand_pos();
    return {8'($urandom_range(255)), $urandom};
  endfunction

  // a coordinate within +-span of base, clamped to the position range
  function automatic logic [39:0] near(logic [39:0] base, longint span);
    longint off, v;
    off = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
    v = longint'(base) + off;
    if (v < 0) v = 0;
    if (v > longint'(PosMax)) v = longint'(PosMax);
    return v[39:0];
  endfunction

  function automatic pair_pos_t mk(logic [39:0] sx, logic [39:0] sy,
                                   logic [39:0] ox, logic [39:0] oy);
    pair_pos_t p;
    p.sx = sx; p.sy = sy; p.ox = ox; p.oy = oy;
    return p;
  endfunction

  task automatic random_pairs(int n);
    pair_pos_t p;
    longint span;
    int pick;
    for (int i = 0; i < n; i++) begin
      p.sx = rand_pos();
      p.sy = rand_pos();
      pick = $urandom_range(9);
      if (pick < 3) begin
        p.ox = rand_pos();
        p.oy = rand_pos();
      end else begin
        span = longint'(sb.cutoff) + longint'(sb.cutoff >> 2) + 1;
        if (pick == 3) span = longint'(sb.min_rad) * 2 + 1;
        if (pick == 4) span = $urandom_range(8);
        p.ox = near(p.sx, span);
        p.oy = near(p.sy, span);
      end
      send_pair(p);
    end
  endtask

  initial begin
    logic [39:0] c0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    tx_idle_pct = 34;
    rx_idle_pct = 59;
    hold_len    = 0;
    quiet_cycles = 0;
    sent        = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners at reset defaults
    c0 = prf_pkg::CutoffRst;
    send_pair(mk(0, 0, 0, 0));
    send_pair(mk(PosMax, PosMax, PosMax, PosMax));
    send_pair(mk(0, 0, PosMax, PosMax));
    send_pair(mk(PosMax, PosMax, 0, 0));
    send_pair(mk(1000, 1000, 1000 + c0, 1000));
    send_pair(mk(1000, 1000, 1001 + c0, 1000));
    send_pair(mk(5000, 5000, 5000, 5000 - c0));
    send_pair(mk(1000, 1000, 1001, 1000));
    send_pair(mk(1000, 1000, 999, 1000));
    send_pair(mk(1000, 1000, 1000, 999));
    send_pair(mk(PosMax, PosMax, PosMax - 100, PosMax - 100));
    send_pair(mk(0, PosMax, 50000, PosMax - 60000));
    send_pair(mk(7, 7, 7 + 1678, 7));
    send_pair(mk(7, 7, 7 + 1677, 7 + 3));
    send_pair(mk(40'hAA_AAAA_AAAA, 40'h55_5555_5555, 40'hAA_AAAA_AAAA + 80000,
                 40'h55_5555_5555 - 90000));
    random_pairs(PerPhase);
    drain();

    // extremes: widest cutoff, smallest clamp, heaviest scaling
    hold_len = 600;
    set_regs(PosMax, 40'd1, 32'hFFFF_FFFF);
    send_pair(mk(0, 0, PosMax, PosMax));
    send_pair(mk(0, 0, 1, 0));
    random_pairs(PerPhase);
    drain();

    // zero clamp and zero inverse mass
    set_regs(40'd167772, 40'd0, 32'd0);
    send_pair(mk(100, 100, 100, 100));
    random_pairs(PerPhase);
    drain();

    tx_idle_pct = 59;
    rx_idle_pct = 34;
    // clamp above cutoff, so the force turns attractive
    set_regs(40'd1000, 40'd50000, 32'd6553600);
    random_pairs(PerPhase);
    drain();

    set_regs(40'd1, 40'd1, 32'd1);
    send_pair(mk(10, 10, 11, 10));
    random_pairs(PerPhase);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_regs(40'($urandom_range(1, 32'h3FFF_FFFF)), 40'($urandom_range(1, 1 << 20)),
             $urandom_range(1, 32'hFFFF_FFFF));
    random_pairs(PerPhase);
    drain();

    // largest clamp
    set_regs(40'h100_0000, PosMax, 32'h1_0000);
    random_pairs(PerPhase);
    drain();

    $display("covered %0d pairs over 7 register settings, %0d within cutoff, %0d results",
             sent, sb.hits, sb.checked);
    $display("with mixed, swapped and no idling on both streams plus a long sink hold-off");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
